[hdl/stkt_pkg.sv]
`timescale 1ns / 1ps

package stkt_pkg;

    // Field limits of a valid time
    localparam int unsigned MONTH_MAX  = 12;
    localparam int unsigned DAY_MAX    = 31;
    localparam int unsigned HOUR_MAX   = 24;
    localparam int unsigned MINUTE_MAX = 59;

    localparam int unsigned KEY_W   = 20;
    localparam int unsigned ENTRY_W = 36;

    typedef enum logic [2:0] {
        STAT_INSERTED    = 3'd0,
        STAT_INVALID     = 3'd1,
        STAT_FULL        = 3'd2,
        STAT_END         = 3'd3,
        STAT_READ_OK     = 3'd4,
        STAT_READ_BEYOND = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_RDWAIT,
        ST_FINISH
    } state_t;

    // Field order makes the upper 20 bits a key that sorts like the time
    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] tag;
    } entry_t;

    function automatic logic [KEY_W-1:0] entry_key(input entry_t e);
        entry_key = {e.month, e.day, e.hour, e.minute};
    endfunction

endpackage

[hdl/stkt_ram.sv]
`timescale 1ns / 1ps

module stkt_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/sorted_time_key_table_core.sv]
`timescale 1ns / 1ps
// Sorted table of time-keyed entries (month, day, hour, minute, 16-bit tag).
// Input channel in_valid/in_ready carries one item: mode 0 inserts an entry,
// mode 1 reads the entry at read_index. Output channel out_valid/out_ready
// returns exactly one result per item: status, insert position, entry count
// and, on a good read, the stored entry fields.
// An insert walks the table from the top slot down through one memory
// port pair: each cycle reads the next lower entry and writes the one just
// read a slot higher until the new key finds its place. One item is in
// work at a time; in_ready is high only while no item is in work.
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled receiver holds the following result in the block
// and in_ready stays low until it can be handed over.
// Reset empties the table at once (count cleared, memory contents unused).
module sorted_time_key_table_core
    import stkt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [6:0]  month,
    input  logic [6:0]  day,
    input  logic [6:0]  hour,
    input  logic [6:0]  minute,
    input  logic [15:0] tag,
    input  logic [5:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [6:0]  position,
    output logic [6:0]  count,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [4:0]  out_hour,
    output logic [5:0]  out_minute,
    output logic [15:0] out_tag
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  j_reg, j_next;
    entry_t         new_reg, new_next;
    entry_t         res_reg, res_next;
    status_t        stat_reg, stat_next;

    logic           out_valid_reg, out_valid_next;
    logic [2:0]     status_reg;
    logic [6:0]     position_reg;
    logic [6:0]     count_out_reg;
    entry_t         out_entry_reg;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    entry_t         ram_wdata, ram_rdata;

    logic           full, time_ok, ridx_ok, key_gt, out_free;
    logic [CW-1:0]  cnt_m1, j_m2;
    logic [CW+5:0]  ridx_w, cnt_w;
    logic [CW+6:0]  cnt_out_w, pos_out_w;
    entry_t         in_entry;

    stkt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign full    = (count_reg == CW'(TABLE_DEPTH));
    assign time_ok = (month <= 7'(MONTH_MAX)) && (day != 7'd0) && (day <= 7'(DAY_MAX))
                     && (hour <= 7'(HOUR_MAX)) && (minute <= 7'(MINUTE_MAX));
    assign ridx_w  = {{CW{1'b0}}, read_index};
    assign cnt_w   = {6'b0, count_reg};
    assign ridx_ok = (ridx_w < cnt_w);
    assign cnt_m1  = count_reg - 1'b1;
    assign j_m2    = j_reg - CW'(2);
    assign key_gt  = (entry_key(ram_rdata) > entry_key(new_reg));
    assign out_free = !out_valid_reg || out_ready;

    assign in_entry.month  = month[3:0];
    assign in_entry.day    = day[4:0];
    assign in_entry.hour   = hour[4:0];
    assign in_entry.minute = minute[5:0];
    assign in_entry.tag    = tag;

    assign cnt_out_w = {7'b0, count_reg};
    assign pos_out_w = {7'b0, j_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode)
                    begin
                        state_next = ridx_ok ? ST_RDWAIT : ST_FINISH;
                    end
                    else if (full || month == 7'd0 || !time_ok)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_PLACE : ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (!key_gt)
                begin
                    state_next = ST_FINISH;
                end
                else if (j_reg == CW'(1))
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:  state_next = ST_FINISH;
            ST_RDWAIT: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        count_next     = count_reg;
        j_next         = j_reg;
        new_next       = new_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        ram_we         = 1'b0;
        ram_waddr      = j_reg[AW-1:0];
        ram_wdata      = new_reg;
        ram_re         = 1'b0;
        ram_raddr      = cnt_m1[AW-1:0];
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    new_next = in_entry;
                    res_next = '0;
                    j_next   = '0;
                    if (mode)
                    begin
                        stat_next = ridx_ok ? STAT_READ_OK : STAT_READ_BEYOND;
                        ram_re    = ridx_ok;
                        ram_raddr = ridx_w[AW-1:0];
                    end
                    else if (full)
                    begin
                        stat_next = STAT_FULL;
                    end
                    else if (month == 7'd0)
                    begin
                        stat_next = STAT_END;
                    end
                    else if (!time_ok)
                    begin
                        stat_next = STAT_INVALID;
                    end
                    else
                    begin
                        // start the walk at the top of the table
                        stat_next = STAT_INSERTED;
                        j_next    = count_reg;
                        ram_re    = (count_reg != '0);
                    end
                end
            end
            ST_SHIFT:
            begin
                ram_we = 1'b1;
                if (key_gt)
                begin
                    // move the larger entry up one slot, read the next lower
                    ram_wdata = ram_rdata;
                    j_next    = j_reg - 1'b1;
                    ram_re    = (j_reg != CW'(1));
                    ram_raddr = j_m2[AW-1:0];
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_PLACE:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + 1'b1;
            end
            ST_RDWAIT:
            begin
                res_next = ram_rdata;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        new_reg  <= new_next;
        res_reg  <= res_next;
        stat_reg <= stat_next;
        if (state_reg == ST_FINISH && out_free)
        begin
            status_reg    <= stat_reg;
            position_reg  <= pos_out_w[6:0];
            count_out_reg <= cnt_out_w[6:0];
            out_entry_reg <= res_reg;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign position   = position_reg;
    assign count      = count_out_reg;
    assign out_month  = out_entry_reg.month;
    assign out_day    = out_entry_reg.day;
    assign out_hour   = out_entry_reg.hour;
    assign out_minute = out_entry_reg.minute;
    assign out_tag    = out_entry_reg.tag;

endmodule

[hdl/stkt_chk.sv]
`timescale 1ns / 1ps

module stkt_chk
    import stkt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [6:0]  position,
    input logic [6:0]  count,
    input logic [3:0]  out_month,
    input logic [4:0]  out_day,
    input logic [4:0]  out_hour,
    input logic [5:0]  out_minute,
    input logic [15:0] out_tag
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
        && $stable(count) && $stable(out_tag))
        else $error("result changed while stalled");

    // Drop ready after an input transfer while the item is in work
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a transfer");

    // An insert result reports a non-empty table, the one it just grew
    a_insert_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_INSERTED |-> count != 7'd0)
        else $error("insert reported with empty table");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_INSERTED |-> position == 7'd0)
        else $error("position set on non-insert result");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_READ_OK |-> out_month == 4'd0 && out_day == 5'd0
        && out_hour == 5'd0 && out_minute == 6'd0 && out_tag == 16'd0)
        else $error("entry fields set on non-read result");

endmodule

bind sorted_time_key_table_core stkt_chk u_stkt_chk (.*);
